// File: rtl/core/roi_minmax_contrast_stretch_defines.svh
// ----------------------------------------------------------------------------
// ROI min/max contrast stretch: assertion macros
// Shared concurrent assertion forms used by the stretch datapath modules.
// ----------------------------------------------------------------------------
`ifndef ROI_MINMAX_CONTRAST_STRETCH_DEFINES_SVH
`define ROI_MINMAX_CONTRAST_STRETCH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RMCS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RMCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/rmcs_pkg.sv
// ----------------------------------------------------------------------------
// rmcs_pkg
// Types and constants shared by the ROI min/max contrast stretch modules.
// ----------------------------------------------------------------------------
package rmcs_pkg;

    // Operation codes carried in the input tuser.
    localparam logic [1:0] FUNC_MEASURE = 2'd0;
    localparam logic [1:0] FUNC_STRETCH = 2'd1;
    localparam logic [1:0] FUNC_FULL    = 2'd2;
    localparam logic [1:0] FUNC_CLEAR   = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_16BIT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROI_LEFT     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROI_TOP      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ROI_RIGHT    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ROI_BOTTOM   = 3'd4;

    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned COORD_W    = 12;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned GREY_W     = 8;

    // Image bound; coordinates at or above it are never measured.
    localparam logic [CFG_DATA_W-1:0] MAX_DIM = 13'd4096;

    localparam logic [SAMPLE_W-1:0] FULL_HIGH_16 = 16'hFFFF;
    localparam logic [SAMPLE_W-1:0] FULL_HIGH_8  = 16'h00FF;
    localparam logic [SAMPLE_W-1:0] WINDOW_LOW_RESET  = 16'hFFFF;
    localparam logic [SAMPLE_W-1:0] WINDOW_HIGH_RESET = 16'h0000;

    localparam logic [GREY_W-1:0] GREY_MAX = 8'd255;

    // Numerator (sample - low) * 255 fits in 24 bits.
    localparam int unsigned NUM_W = SAMPLE_W + GREY_W;

    // Queue between the front and the mapping unit.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = 1;
    localparam int unsigned QUEUE_CNT_W = 2;

    // One mapping job: masked sample and the window chosen for it.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [SAMPLE_W-1:0] low;
        logic [SAMPLE_W-1:0] high;
    } map_job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } map_state_t;

endpackage

// File: rtl/core/rmcs_front.sv
// ----------------------------------------------------------------------------
// rmcs_front
// Accepts pixel items, holds the configuration, tracks the ROI window and
// queues mapping jobs for the stretch unit.
// ----------------------------------------------------------------------------
module rmcs_front (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wr_en,
    input  logic [rmcs_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [rmcs_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [1:0]                              s_tuser,  // func
    input  logic [39:0]                             s_tdata,  // pixel_x, pixel_y, sample
    input  logic                                    q_full,
    output logic                                    q_push,
    output rmcs_pkg::map_job_t                      q_job
);

    logic                                sample_16bit_reg;
    logic [rmcs_pkg::CFG_DATA_W-1:0]     roi_left_reg;
    logic [rmcs_pkg::CFG_DATA_W-1:0]     roi_top_reg;
    logic [rmcs_pkg::CFG_DATA_W-1:0]     roi_right_reg;
    logic [rmcs_pkg::CFG_DATA_W-1:0]     roi_bottom_reg;
    logic [rmcs_pkg::SAMPLE_W-1:0]       win_low_reg;
    logic [rmcs_pkg::SAMPLE_W-1:0]       win_high_reg;
    logic [rmcs_pkg::SAMPLE_W-1:0]       win_low_next;
    logic [rmcs_pkg::SAMPLE_W-1:0]       win_high_next;

    logic                                accept;
    logic [1:0]                          func;
    logic [rmcs_pkg::CFG_DATA_W-1:0]     px;
    logic [rmcs_pkg::CFG_DATA_W-1:0]     py;
    logic [rmcs_pkg::SAMPLE_W-1:0]       value;
    logic                                in_image;
    logic                                in_roi;
    logic                                win_valid;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign func     = s_tuser;
    assign px       = {1'b0, s_tdata[11:0]};
    assign py       = {1'b0, s_tdata[23:12]};
    // In 8-bit mode the upper byte of the sample is ignored throughout.
    assign value    = sample_16bit_reg ? s_tdata[39:24] : {8'h00, s_tdata[31:24]};

    assign in_image = (px < rmcs_pkg::MAX_DIM) && (py < rmcs_pkg::MAX_DIM);
    assign in_roi   = (px >= roi_left_reg) && (px < roi_right_reg) &&
                      (py >= roi_top_reg) && (py < roi_bottom_reg);
    assign win_valid = (win_low_reg <= win_high_reg);

    always_comb begin
        win_low_next  = win_low_reg;
        win_high_next = win_high_reg;
        q_push        = 1'b0;
        q_job.sample  = value;
        q_job.low     = '0;
        q_job.high    = sample_16bit_reg ? rmcs_pkg::FULL_HIGH_16 : rmcs_pkg::FULL_HIGH_8;
        if (func == rmcs_pkg::FUNC_STRETCH && win_valid) begin
            q_job.low  = win_low_reg;
            q_job.high = win_high_reg;
        end
        if (accept) begin
            case (func)
                rmcs_pkg::FUNC_MEASURE: begin
                    if (in_image && in_roi) begin
                        if (value < win_low_reg) begin
                            win_low_next = value;
                        end
                        if (value > win_high_reg) begin
                            win_high_next = value;
                        end
                    end
                end
                rmcs_pkg::FUNC_CLEAR: begin
                    win_low_next  = rmcs_pkg::WINDOW_LOW_RESET;
                    win_high_next = rmcs_pkg::WINDOW_HIGH_RESET;
                end
                rmcs_pkg::FUNC_STRETCH, rmcs_pkg::FUNC_FULL: begin
                    q_push = 1'b1;
                end
                default: begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_16bit_reg <= 1'b1;
            roi_left_reg     <= '0;
            roi_top_reg      <= '0;
            roi_right_reg    <= '0;
            roi_bottom_reg   <= '0;
            win_low_reg      <= rmcs_pkg::WINDOW_LOW_RESET;
            win_high_reg     <= rmcs_pkg::WINDOW_HIGH_RESET;
        end else begin
            win_low_reg  <= win_low_next;
            win_high_reg <= win_high_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    rmcs_pkg::REG_SAMPLE_16BIT: sample_16bit_reg <= cfg_wdata[0];
                    rmcs_pkg::REG_ROI_LEFT:     roi_left_reg     <= cfg_wdata;
                    rmcs_pkg::REG_ROI_TOP:      roi_top_reg      <= cfg_wdata;
                    rmcs_pkg::REG_ROI_RIGHT:    roi_right_reg    <= cfg_wdata;
                    rmcs_pkg::REG_ROI_BOTTOM:   roi_bottom_reg   <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// File: rtl/core/rmcs_queue.sv
// ----------------------------------------------------------------------------
// rmcs_queue
// Short FIFO of mapping jobs between the front and the stretch unit.
// ----------------------------------------------------------------------------
`include "roi_minmax_contrast_stretch_defines.svh"

module rmcs_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  rmcs_pkg::map_job_t  push_job,
    output logic                full,
    input  logic                pop,
    output rmcs_pkg::map_job_t  pop_job,
    output logic                empty
);

    rmcs_pkg::map_job_t                  mem_reg [rmcs_pkg::QUEUE_DEPTH];
    logic [rmcs_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [rmcs_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [rmcs_pkg::QUEUE_CNT_W-1:0]    count_reg;
    logic [rmcs_pkg::QUEUE_CNT_W-1:0]    count_next;

    localparam logic [rmcs_pkg::QUEUE_CNT_W-1:0] CountFull =
        rmcs_pkg::QUEUE_CNT_W'(rmcs_pkg::QUEUE_DEPTH);

    assign full    = (count_reg == CountFull);
    assign empty   = (count_reg == '0);
    assign pop_job = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    `RMCS_ASSERT_IMPLIES(a_no_push_full, aclk, aresetn, push, !full, "push into a full queue")
    `RMCS_ASSERT_IMPLIES(a_no_pop_empty, aclk, aresetn, pop, !empty, "pop from an empty queue")
    `RMCS_ASSERT_IMPLIES(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CountFull, "queue count overflow")

endmodule

// File: rtl/core/rmcs_back.sv
// ----------------------------------------------------------------------------
// rmcs_back
// Stretch unit: maps one queued sample over its window with an 8-step
// restoring divider and holds the result in the output register.
// ----------------------------------------------------------------------------
`include "roi_minmax_contrast_stretch_defines.svh"

module rmcs_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  rmcs_pkg::map_job_t  q_job,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata    // grey, used_low, used_high
);

    rmcs_pkg::map_state_t              st_reg;
    rmcs_pkg::map_state_t              st_next;
    logic [rmcs_pkg::NUM_W-1:0]        rem_reg;
    logic [rmcs_pkg::NUM_W-1:0]        rem_next;
    logic [rmcs_pkg::NUM_W-1:0]        dsh_reg;
    logic [rmcs_pkg::NUM_W-1:0]        dsh_next;
    logic [rmcs_pkg::GREY_W-1:0]       quo_reg;
    logic [rmcs_pkg::GREY_W-1:0]       quo_next;
    logic [2:0]                        step_reg;
    logic [2:0]                        step_next;
    logic [rmcs_pkg::SAMPLE_W-1:0]     low_reg;
    logic [rmcs_pkg::SAMPLE_W-1:0]     low_next;
    logic [rmcs_pkg::SAMPLE_W-1:0]     high_reg;
    logic [rmcs_pkg::SAMPLE_W-1:0]     high_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [39:0]                       out_data_reg;
    logic [39:0]                       out_data_next;

    logic [rmcs_pkg::SAMPLE_W-1:0]     diff;
    logic [rmcs_pkg::SAMPLE_W-1:0]     range;
    logic                              out_free;

    assign diff     = q_job.sample - q_job.low;
    assign range    = q_job.high - q_job.low;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        st_next        = st_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        case (st_reg)
            rmcs_pkg::ST_IDLE: begin
                if (!q_empty) begin
                    q_pop     = 1'b1;
                    low_next  = q_job.low;
                    high_next = q_job.high;
                    // diff * 255 as a shift and subtract.
                    rem_next  = {diff, 8'h00} - {8'h00, diff};
                    dsh_next  = {1'b0, range, 7'h00};
                    step_next = '0;
                    if (q_job.sample <= q_job.low) begin
                        quo_next = '0;
                        st_next  = rmcs_pkg::ST_DONE;
                    end else if (q_job.sample >= q_job.high) begin
                        // Also covers a window with high at or below low.
                        quo_next = rmcs_pkg::GREY_MAX;
                        st_next  = rmcs_pkg::ST_DONE;
                    end else begin
                        quo_next = '0;
                        st_next  = rmcs_pkg::ST_DIV;
                    end
                end
            end
            rmcs_pkg::ST_DIV: begin
                if (rem_reg >= dsh_reg) begin
                    rem_next = rem_reg - dsh_reg;
                    quo_next = {quo_reg[6:0], 1'b1};
                end else begin
                    quo_next = {quo_reg[6:0], 1'b0};
                end
                dsh_next  = {1'b0, dsh_reg[rmcs_pkg::NUM_W-1:1]};
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd7) begin
                    st_next = rmcs_pkg::ST_DONE;
                end
            end
            rmcs_pkg::ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {high_reg, low_reg, quo_reg};
                    st_next        = rmcs_pkg::ST_IDLE;
                end
            end
            default: begin
                st_next = rmcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= rmcs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        quo_reg      <= quo_next;
        step_reg     <= step_next;
        low_reg      <= low_next;
        high_reg     <= high_next;
        out_data_reg <= out_data_next;
    end

    // The partial remainder always stays below twice the shifted divisor.
    `RMCS_ASSERT_IMPLIES(a_rem_bound, aclk, aresetn, st_reg == rmcs_pkg::ST_DIV,
        {1'b0, rem_reg} < {dsh_reg, 1'b0}, "divider remainder out of range")
    `RMCS_ASSERT_NEXT(a_div_ends, aclk, aresetn,
        st_reg == rmcs_pkg::ST_DIV && step_reg == 3'd7,
        st_reg == rmcs_pkg::ST_DONE, "divider did not finish after eight steps")
    `RMCS_ASSERT_IMPLIES(a_window_order, aclk, aresetn, out_valid_reg,
        out_data_reg[23:8] <= out_data_reg[39:24], "reported window low above high")

endmodule

// File: rtl/core/roi_minmax_contrast_stretch.sv
// ----------------------------------------------------------------------------
// roi_minmax_contrast_stretch
// Min/max contrast stretch with a learned window from a region of interest.
// ----------------------------------------------------------------------------
// Measure and clear items are taken one per cycle while the job queue has room.
// A stretch or full-range item is loaded from the job queue to the stretch unit, which
// runs 8 divider steps unless its sample clamps to grey 0 or 255, then raises m_tvalid;
// the unit finishes one mapping (load, divider steps, output) before it loads the next.
// Reset (aresetn low, synchronous) empties the queue and output, sets
// 16-bit mode, an empty region and an empty window.
module roi_minmax_contrast_stretch (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rmcs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [rmcs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [1:0]                          s_tuser,  // func
    input  logic [39:0]                         s_tdata,  // pixel_x, pixel_y, sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [39:0]                         m_tdata   // grey, used_low, used_high
);

    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_empty;
    rmcs_pkg::map_job_t  push_job;
    rmcs_pkg::map_job_t  pop_job;

    rmcs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    rmcs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    rmcs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_job    (pop_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: bench/roi_stretch_checker.sv
// ----------------------------------------------------------------------------
// roi_stretch_checker
// Watches the pixel, grey and register ports of the contrast stretch block,
// keeps its own copy of the region, mode and learned window, and compares
// every grey transaction field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module roi_stretch_checker
    import rmcs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [1:0]            s_tuser,   // func
    input  logic [39:0]           s_tdata,   // pixel_x, pixel_y, sample
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [39:0]           m_tdata,   // grey, used_low, used_high
    output int unsigned           outstanding,
    output int unsigned           fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [GREY_W-1:0]   grey;
        logic [SAMPLE_W-1:0] low;
        logic [SAMPLE_W-1:0] high;
    } grey_result_t;

    grey_result_t pending_greys[$];

    logic                  mode_16bit;
    logic [CFG_DATA_W-1:0] roi_left;
    logic [CFG_DATA_W-1:0] roi_top;
    logic [CFG_DATA_W-1:0] roi_right;
    logic [CFG_DATA_W-1:0] roi_bottom;
    logic [SAMPLE_W-1:0]   win_low;
    logic [SAMPLE_W-1:0]   win_high;

    initial fail_count = 0;

    function automatic logic [GREY_W-1:0] stretch_grey(input logic [SAMPLE_W-1:0] v,
                                                       input logic [SAMPLE_W-1:0] lo,
                                                       input logic [SAMPLE_W-1:0] hi);
        logic [31:0] scaled;
        if (v <= lo) return '0;
        if (hi <= lo) return GREY_MAX;
        scaled = (32'(v - lo) * 32'd255) / 32'(hi - lo);
        return (scaled > 32'd255) ? GREY_MAX : scaled[GREY_W-1:0];
    endfunction

    task automatic report_field(input string field, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        logic [1:0]          func;
        logic [COORD_W-1:0]  px;
        logic [COORD_W-1:0]  py;
        logic [SAMPLE_W-1:0] v;
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        logic                in_region;
        grey_result_t        want;

        if (!aresetn) begin
            mode_16bit = 1'b1;
            roi_left   = '0;
            roi_top    = '0;
            roi_right  = '0;
            roi_bottom = '0;
            win_low    = WINDOW_LOW_RESET;
            win_high   = WINDOW_HIGH_RESET;
            pending_greys.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_SAMPLE_16BIT: mode_16bit = cfg_wdata[0];
                    REG_ROI_LEFT:     roi_left   = cfg_wdata;
                    REG_ROI_TOP:      roi_top    = cfg_wdata;
                    REG_ROI_RIGHT:    roi_right  = cfg_wdata;
                    REG_ROI_BOTTOM:   roi_bottom = cfg_wdata;
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                if (pending_greys.size() == 0) begin
                    $display("%0t ns: unexpected grey transaction, expected none, actual %h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = pending_greys.pop_front();
                    report_field("grey", want.grey, m_tdata[7:0]);
                    report_field("used_low", want.low, m_tdata[23:8]);
                    report_field("used_high", want.high, m_tdata[39:24]);
                end
            end

            if (s_tvalid && s_tready) begin
                func = s_tuser;
                px   = s_tdata[11:0];
                py   = s_tdata[23:12];
                v    = s_tdata[39:24];
                // In 8-bit mode the upper byte is noise for both measuring and mapping.
                if (!mode_16bit) v[15:8] = '0;
                case (func)
                    FUNC_MEASURE: begin
                        in_region = ({1'b0, px} >= roi_left) && ({1'b0, px} < roi_right) &&
                                    ({1'b0, py} >= roi_top) && ({1'b0, py} < roi_bottom) &&
                                    ({1'b0, px} < MAX_DIM) && ({1'b0, py} < MAX_DIM);
                        if (in_region) begin
                            if (v < win_low) win_low = v;
                            if (v > win_high) win_high = v;
                        end
                    end
                    FUNC_CLEAR: begin
                        win_low  = WINDOW_LOW_RESET;
                        win_high = WINDOW_HIGH_RESET;
                    end
                    default: begin
                        // An empty window (low above high) falls back to the full range.
                        if (func == FUNC_STRETCH && win_low <= win_high) begin
                            lo = win_low;
                            hi = win_high;
                        end else begin
                            lo = '0;
                            hi = mode_16bit ? FULL_HIGH_16 : FULL_HIGH_8;
                        end
                        pending_greys.push_back('{stretch_grey(v, lo, hi), lo, hi});
                    end
                endcase
            end
        end
        outstanding <= pending_greys.size();
    end

endmodule

// File: bench/tb_roi_minmax_contrast_stretch.sv
// ----------------------------------------------------------------------------
// tb_roi_minmax_contrast_stretch
// Drives pixel items and register writes into the contrast stretch block
// with random idle gaps on both streams and one long output stall; the
// checker beside the block predicts and compares every grey transaction.
// ----------------------------------------------------------------------------
module tb_roi_minmax_contrast_stretch;
    timeunit 1ns;
    timeprecision 1ps;
    import rmcs_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned RANDOM_PHASES   = 6;
    localparam int unsigned PHASE_ITEMS     = 92;
    localparam int unsigned SETTLE_CYCLES   = 30;
    localparam int unsigned HOLD_OFF_AFTER  = 60;
    localparam int unsigned HOLD_OFF_CYCLES = 400;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [1:0]            s_tuser   = '0;   // func
    logic [39:0]           s_tdata   = '0;   // pixel_x, pixel_y, sample
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [39:0]           m_tdata;          // grey, used_low, used_high

    int unsigned outstanding;
    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned sender_calm = 0;

    // Stimulus copy of the current mode, region and sample scene.
    logic                  mode16;
    logic [CFG_DATA_W-1:0] roi_l, roi_t, roi_r, roi_b;
    int unsigned           scene_lo, scene_hi;

    always #5 aclk = ~aclk;

    roi_minmax_contrast_stretch u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    roi_stretch_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    // Mostly short gaps, sometimes longer ones, and now and then a calm run with none.
    task automatic draw_gap(inout int unsigned calm, output int unsigned gap);
        if (calm > 0) begin
            calm--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 40);
            gap = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2) : $urandom_range(0, 16);
        end
    endtask

    task automatic send_pixel(input logic [1:0] func, input logic [COORD_W-1:0] px,
                              input logic [COORD_W-1:0] py, input logic [SAMPLE_W-1:0] v);
        int unsigned gap;
        draw_gap(sender_calm, gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tuser  <= func;
        s_tdata  <= {v, py, px};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Waits until every grey result is back, then waits out SETTLE_CYCLES before
    // the registers are touched.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic set_region(input logic mode, input logic [CFG_DATA_W-1:0] left,
                              input logic [CFG_DATA_W-1:0] top_row,
                              input logic [CFG_DATA_W-1:0] right,
                              input logic [CFG_DATA_W-1:0] bottom, input bit with_stray);
        mode16 = mode;
        roi_l  = left;
        roi_t  = top_row;
        roi_r  = right;
        roi_b  = bottom;
        write_reg(REG_SAMPLE_16BIT, {{(CFG_DATA_W-1){1'b0}}, mode});
        write_reg(REG_ROI_LEFT, left);
        write_reg(REG_ROI_TOP, top_row);
        write_reg(REG_ROI_RIGHT, right);
        write_reg(REG_ROI_BOTTOM, bottom);
        // Indexes past the register list must be ignored by the block.
        if (with_stray || $urandom_range(0, 2) == 0)
            write_reg(CFG_ADDR_W'($urandom_range(int'(REG_ROI_BOTTOM) + 1,
                                                 (1 << CFG_ADDR_W) - 1)),
                      CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic new_scene();
        int unsigned full_hi, span;
        full_hi  = mode16 ? 65535 : 255;
        scene_lo = $urandom_range(0, full_hi);
        case ($urandom_range(0, 3))
            0:       span = 0;
            1:       span = $urandom_range(0, 8);
            default: span = $urandom_range(0, full_hi - scene_lo);
        endcase
        scene_hi = (scene_lo + span > full_hi) ? full_hi : scene_lo + span;
    endtask

    function automatic logic [SAMPLE_W-1:0] draw_sample(input bit for_measure);
        int unsigned full_hi, lo, hi, r;
        logic [SAMPLE_W-1:0] v;
        full_hi = mode16 ? 65535 : 255;
        r = $urandom_range(0, 99);
        if (for_measure || r < 70) begin
            lo = for_measure ? scene_lo : ((scene_lo > 16) ? scene_lo - 16 : 0);
            hi = for_measure ? scene_hi : ((scene_hi + 16 > full_hi) ? full_hi : scene_hi + 16);
            v  = SAMPLE_W'($urandom_range(lo, hi));
        end else if (r < 85) begin
            v = ($urandom_range(0, 1) == 0) ? '0 : SAMPLE_W'(full_hi);
        end else begin
            v = SAMPLE_W'($urandom);
        end
        if (!mode16) v[15:8] = 8'($urandom);
        return v;
    endfunction

    // Mostly a coordinate inside [lo, hi), otherwise one just outside or anywhere.
    function automatic logic [COORD_W-1:0] pick_coord(input logic [CFG_DATA_W-1:0] lo,
                                                      input logic [CFG_DATA_W-1:0] hi);
        int unsigned r, last;
        r = $urandom_range(0, 9);
        if (r < 7 && hi > lo && lo < MAX_DIM) begin
            last = (hi > MAX_DIM) ? MAX_DIM - 1 : hi - 1;
            return COORD_W'($urandom_range(lo, last));
        end
        if (r < 9) begin
            case ($urandom_range(0, 3))
                0:       if (lo > 0 && lo <= MAX_DIM) return COORD_W'(lo - 1);
                1:       if (hi < MAX_DIM) return COORD_W'(hi);
                2:       return '0;
                default: return '1;
            endcase
        end
        return COORD_W'($urandom);
    endfunction

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Grey sink: random stalls, plus one long hold-off that backs the block up.
    initial begin : grey_sink
        int unsigned gap, taken, calm;
        taken = 0;
        calm  = 0;
        forever begin
            if (taken == HOLD_OFF_AFTER) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            draw_gap(calm, gap);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            taken++;
        end
    end

    initial begin : stimulus
        int unsigned r, ph, i;
        logic [CFG_DATA_W-1:0] l, t, rt, b;

        mode16 = 1'b1;
        roi_l  = '0;
        roi_t  = '0;
        roi_r  = '0;
        roi_b  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset state: empty region and empty window, so everything maps over the full range.
        send_pixel(FUNC_STRETCH, '0, '0, 16'h0000);
        send_pixel(FUNC_FULL, '1, '1, 16'hFFFF);
        send_pixel(FUNC_MEASURE, '0, '0, 16'd1234);
        send_pixel(FUNC_STRETCH, '0, '0, 16'd1234);
        settle();

        // Region edges: left and top are inside, right and bottom are not.
        set_region(1'b1, 13'd10, 13'd20, 13'd30, 13'd40, 1'b1);
        send_pixel(FUNC_MEASURE, 12'd10, 12'd20, 16'd1000);
        send_pixel(FUNC_MEASURE, 12'd29, 12'd39, 16'd3000);
        send_pixel(FUNC_MEASURE, 12'd30, 12'd25, 16'd0);
        send_pixel(FUNC_MEASURE, 12'd15, 12'd40, 16'd65535);
        send_pixel(FUNC_MEASURE, 12'd9, 12'd25, 16'd5);
        send_pixel(FUNC_MEASURE, 12'd15, 12'd19, 16'd5);
        send_pixel(FUNC_STRETCH, '0, '0, 16'd999);
        send_pixel(FUNC_STRETCH, '0, '0, 16'd2000);
        send_pixel(FUNC_STRETCH, '0, '0, 16'd3000);
        send_pixel(FUNC_STRETCH, '0, '0, 16'd65535);
        send_pixel(FUNC_FULL, '0, '0, 16'd32768);
        send_pixel(FUNC_CLEAR, '0, '0, 16'd0);
        send_pixel(FUNC_STRETCH, '0, '0, 16'd500);
        // A single measured sample gives equal low and high.
        send_pixel(FUNC_MEASURE, 12'd12, 12'd22, 16'd700);
        send_pixel(FUNC_STRETCH, '0, '0, 16'd700);
        send_pixel(FUNC_STRETCH, '0, '0, 16'd701);
        settle();

        // 8-bit mode keeps the window learned in 16-bit mode until it is cleared.
        set_region(1'b0, '0, '0, MAX_DIM, MAX_DIM, 1'b0);
        send_pixel(FUNC_STRETCH, '0, '0, 16'h12C8);
        send_pixel(FUNC_FULL, '0, '0, 16'hFFFF);
        send_pixel(FUNC_CLEAR, '0, '0, 16'hFFFF);
        send_pixel(FUNC_MEASURE, '1, '1, 16'hFF10);
        send_pixel(FUNC_STRETCH, '0, '0, 16'hAA11);

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            l  = CFG_DATA_W'($urandom_range(0, 4000));
            rt = CFG_DATA_W'($urandom_range(l, MAX_DIM));
            t  = CFG_DATA_W'($urandom_range(0, 4000));
            b  = CFG_DATA_W'($urandom_range(t, MAX_DIM));
            case (ph)
                0: set_region(1'b1, '0, '0, MAX_DIM, MAX_DIM, 1'b0);
                1: set_region(1'b0, l, t, rt, b, 1'b0);
                // Left equal to right: nothing is ever measured.
                2: set_region(1'b1, MAX_DIM, t, MAX_DIM, b, 1'b0);
                3: set_region(1'b1, MAX_DIM - 1, '0, MAX_DIM, MAX_DIM, 1'b1);
                4: set_region(1'b0, '0, '0, MAX_DIM, MAX_DIM, 1'b0);
                default: set_region(1'($urandom), l, t, rt, b, 1'b0);
            endcase
            new_scene();
            for (i = 0; i < PHASE_ITEMS; i++) begin
                r = $urandom_range(0, 99);
                if (r < 42) begin
                    send_pixel(FUNC_MEASURE, pick_coord(roi_l, roi_r), pick_coord(roi_t, roi_b),
                               draw_sample(1'b1));
                end else if (r < 80) begin
                    send_pixel(FUNC_STRETCH, COORD_W'($urandom), COORD_W'($urandom),
                               draw_sample(1'b0));
                end else if (r < 96) begin
                    send_pixel(FUNC_FULL, COORD_W'($urandom), COORD_W'($urandom),
                               draw_sample(1'b0));
                end else begin
                    send_pixel(FUNC_CLEAR, COORD_W'($urandom), COORD_W'($urandom),
                               SAMPLE_W'($urandom));
                    new_scene();
                end
            end
        end

        settle();
        if (fail_count == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/rmcs_pkg.sv
rtl/core/rmcs_front.sv
rtl/core/rmcs_queue.sv
rtl/core/rmcs_back.sv
rtl/core/roi_minmax_contrast_stretch.sv
bench/roi_stretch_checker.sv
bench/tb_roi_minmax_contrast_stretch.sv
